// ----- rtl/wmmm_pkg.sv -----
// ----------------------------------------------------------------------------
// wmmm_pkg
// Shared types and constants for the windowed min / mean / max unit.
// ----------------------------------------------------------------------------
package wmmm_pkg;

    localparam int SAMPLE_BITS_DEF = 16;
    localparam int LEN_BITS        = 8;
    localparam int OUT_BITS        = 16;
    localparam int OUT_FIELDS      = 4;

    localparam logic [LEN_BITS-1:0] LEN_RESET = 8'd80;
    localparam logic [OUT_BITS-1:0] OUT_MAX   = 16'hFFFF;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_EVAL,
        ST_DIV,
        ST_LATCH
    } state_t;

    // controller to datapath
    typedef struct packed {
        logic cap;        // capture incoming sample
        logic acc;        // fold sample into the running window
        logic div_start;  // load the divider with the running sum
        logic div_step;   // one quotient bit
        logic latch;      // update held statistics, clear window
        logic out_load;   // load output register
    } cmd_t;

    // datapath to controller
    typedef struct packed {
        logic close;      // window full: this item closes it
        logic div_last;   // final quotient bit this cycle
        logic slot_free;  // output register can take a word
    } sts_t;

endpackage

// ----- rtl/wmmm_ctrl.sv -----
// ----------------------------------------------------------------------------
// wmmm_ctrl
// Sequencer: takes a word, accumulates or runs the divide, then loads output.
// ----------------------------------------------------------------------------
module wmmm_ctrl (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          s_tvalid,
    output logic          s_tready,
    input  wmmm_pkg::sts_t sts,
    output wmmm_pkg::cmd_t cmd
);

    wmmm_pkg::state_t state_reg;
    wmmm_pkg::state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= wmmm_pkg::ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        s_tready   = 1'b0;
        case (state_reg)
            wmmm_pkg::ST_IDLE:
            begin
                s_tready = 1'b1;
                if (s_tvalid)
                begin
                    cmd.cap    = 1'b1;
                    state_next = wmmm_pkg::ST_EVAL;
                end
            end
            wmmm_pkg::ST_EVAL:
            begin
                if (sts.close)
                begin
                    cmd.div_start = 1'b1;
                    state_next    = wmmm_pkg::ST_DIV;
                end
                else if (sts.slot_free)
                begin
                    cmd.acc      = 1'b1;
                    cmd.out_load = 1'b1;
                    state_next   = wmmm_pkg::ST_IDLE;
                end
            end
            wmmm_pkg::ST_DIV:
            begin
                cmd.div_step = 1'b1;
                if (sts.div_last)
                begin
                    state_next = wmmm_pkg::ST_LATCH;
                end
            end
            wmmm_pkg::ST_LATCH:
            begin
                if (sts.slot_free)
                begin
                    cmd.latch    = 1'b1;
                    cmd.out_load = 1'b1;
                    state_next   = wmmm_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = wmmm_pkg::ST_IDLE;
            end
        endcase
    end

endmodule

// ----- rtl/wmmm_dp.sv -----
// ----------------------------------------------------------------------------
// wmmm_dp
// Window accumulators, bit-serial restoring divider, held statistics and
// output register.
// ----------------------------------------------------------------------------
module wmmm_dp #(
    parameter int SAMPLE_BITS = wmmm_pkg::SAMPLE_BITS_DEF
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  wmmm_pkg::cmd_t                    cmd,
    output wmmm_pkg::sts_t                    sts,
    input  logic                              cfg_valid,
    input  logic [wmmm_pkg::LEN_BITS-1:0]     cfg_data,
    input  logic [SAMPLE_BITS-1:0]            sample,
    input  logic                              m_tready,
    output logic                              m_tvalid,
    output logic [wmmm_pkg::OUT_FIELDS*wmmm_pkg::OUT_BITS-1:0] m_tdata,
    output logic                              m_tuser
);

    localparam int LW  = wmmm_pkg::LEN_BITS;
    localparam int OW  = wmmm_pkg::OUT_BITS;
    localparam int SW  = SAMPLE_BITS + LW;
    localparam int CW  = SW + 1;
    localparam int DCW = $clog2(SW);

    logic [LW-1:0]          len_reg;
    logic [LW-1:0]          count_reg;
    logic [SW-1:0]          sum_reg;
    logic [SAMPLE_BITS-1:0] min_reg;
    logic [SAMPLE_BITS-1:0] max_reg;
    logic [SAMPLE_BITS-1:0] sample_reg;
    logic [OW-1:0]          smin_reg, smin_next;
    logic [OW-1:0]          smean_reg, smean_next;
    logic [OW-1:0]          smax_reg, smax_next;
    logic [SW-1:0]          quo_reg;
    logic [LW-1:0]          rem_reg;
    logic [DCW-1:0]         dcnt_reg;
    logic                   ovalid_reg;
    logic [OW*wmmm_pkg::OUT_FIELDS-1:0] odata_reg;
    logic                   odone_reg;

    logic [LW-1:0] divisor;
    logic [LW:0]   rem_shift;
    logic          q_bit;
    logic [CW-1:0] quo_ext;

    assign divisor   = (len_reg == '0) ? LW'(1) : len_reg;
    assign rem_shift = {rem_reg, quo_reg[SW-1]};
    assign q_bit     = (rem_shift >= {1'b0, divisor});
    assign quo_ext   = CW'(quo_reg);

    assign sts.close     = (count_reg >= len_reg);
    assign sts.div_last  = (dcnt_reg == '0);
    assign sts.slot_free = !ovalid_reg || m_tready;

    // next held statistics (only differ from current on a window close)
    always_comb
    begin
        smin_next  = smin_reg;
        smean_next = smean_reg;
        smax_next  = smax_reg;
        if (cmd.latch)
        begin
            smin_next  = OW'(min_reg);
            smax_next  = OW'(max_reg);
            smean_next = (quo_ext > CW'(wmmm_pkg::OUT_MAX)) ? wmmm_pkg::OUT_MAX
                                                             : OW'(quo_reg);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            len_reg    <= wmmm_pkg::LEN_RESET;
            count_reg  <= '0;
            sum_reg    <= '0;
            min_reg    <= '0;
            max_reg    <= '0;
            smin_reg   <= '0;
            smean_reg  <= '0;
            smax_reg   <= '0;
            ovalid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_valid)
            begin
                len_reg <= cfg_data;
            end
            if (cmd.acc)
            begin
                count_reg <= count_reg + LW'(1);
                sum_reg   <= sum_reg + SW'(sample_reg);
                if (count_reg == '0 || sample_reg < min_reg)
                begin
                    min_reg <= sample_reg;
                end
                if (sample_reg > max_reg)
                begin
                    max_reg <= sample_reg;
                end
            end
            else if (cmd.latch)
            begin
                count_reg <= '0;
                sum_reg   <= '0;
                min_reg   <= '0;
                max_reg   <= '0;
            end
            smin_reg  <= smin_next;
            smean_reg <= smean_next;
            smax_reg  <= smax_next;
            if (cmd.out_load)
            begin
                ovalid_reg <= 1'b1;
            end
            else if (m_tready)
            begin
                ovalid_reg <= 1'b0;
            end
        end
    end

    // payload: sample capture, divider, output word
    // remainder stays below the divisor, so LW bits hold it
    always_ff @(posedge clk)
    begin
        if (cmd.cap)
        begin
            sample_reg <= sample;
        end
        if (cmd.div_start)
        begin
            quo_reg  <= sum_reg;
            rem_reg  <= '0;
            dcnt_reg <= DCW'(SW - 1);
        end
        else if (cmd.div_step)
        begin
            quo_reg  <= {quo_reg[SW-2:0], q_bit};
            rem_reg  <= LW'(q_bit ? (rem_shift - {1'b0, divisor}) : rem_shift);
            dcnt_reg <= dcnt_reg - DCW'(1);
        end
        if (cmd.out_load)
        begin
            odata_reg <= {smax_next, smean_next, smin_next, OW'(sample_reg)};
            odone_reg <= cmd.latch;
        end
    end

    assign m_tvalid = ovalid_reg;
    assign m_tdata  = odata_reg;
    assign m_tuser  = odone_reg;

endmodule

// ----- rtl/windowed_min_mean_max_unit.sv -----
// Flow: a word that does not close a window is captured, folded into the running
// window and loaded into the output register; a closing word first runs a bit-serial
// divide of the running sum, one quotient bit per cycle, then loads the output.
// A new word is accepted only after the previous one is loaded into the output.
// Reset (rst_n, async, active low): window length 80, accumulators and held
// statistics zero, output empty.
// ----------------------------------------------------------------------------
// windowed_min_mean_max_unit
// Windowed minimum, truncated mean and maximum of a raw sample stream.
// ----------------------------------------------------------------------------
module windowed_min_mean_max_unit #(
    parameter int SAMPLE_BITS = wmmm_pkg::SAMPLE_BITS_DEF
) (
    input  logic                                   clk,
    input  logic                                   rst_n,
    input  logic                                   s_tvalid,
    output logic                                   s_tready,
    input  logic [((SAMPLE_BITS+7)/8)*8-1:0]       s_tdata,   // sample
    output logic                                   m_tvalid,
    input  logic                                   m_tready,
    // raw_now, held_min, held_mean, held_max (16 bits each)
    output logic [wmmm_pkg::OUT_FIELDS*wmmm_pkg::OUT_BITS-1:0] m_tdata,
    output logic                                   m_tuser,   // window_done
    input  logic                                   cfg_valid,
    output logic                                   cfg_ready,
    input  logic [wmmm_pkg::LEN_BITS-1:0]          cfg_data   // window_len
);

    wmmm_pkg::cmd_t cmd;
    wmmm_pkg::sts_t sts;

    assign cfg_ready = 1'b1;

    wmmm_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .sts      (sts),
        .cmd      (cmd)
    );

    wmmm_dp #(
        .SAMPLE_BITS (SAMPLE_BITS)
    ) u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd),
        .sts       (sts),
        .cfg_valid (cfg_valid),
        .cfg_data  (cfg_data),
        .sample    (s_tdata[SAMPLE_BITS-1:0]),
        .m_tready  (m_tready),
        .m_tvalid  (m_tvalid),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser)
    );

    // statistics are only latched into a free output slot
    assert property (@(posedge clk) disable iff (!rst_n)
        cmd.latch |-> sts.slot_free)
        else $error("latch without free output slot");

    // a full window must never accumulate another sample
    assert property (@(posedge clk) disable iff (!rst_n)
        cmd.acc |-> !sts.close)
        else $error("accumulate into a full window");

    // divider runs more than one step
    assert property (@(posedge clk) disable iff (!rst_n)
        cmd.div_start |=> (cmd.div_step && !sts.div_last))
        else $error("divider sequence broken");

    // a closing word always reports window_done
    assert property (@(posedge clk) disable iff (!rst_n)
        cmd.latch |=> (m_tvalid && m_tuser))
        else $error("window close not flagged");

endmodule

// ----- verif/windowed_min_mean_max_unit_test.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// windowed_min_mean_max_unit_test
// Streams raw samples into the unit across many window lengths and idling
// patterns. Every output word is checked field by field against a predicted
// min / mean / max, including saturation and windows that close early.
// ----------------------------------------------------------------------------
module windowed_min_mean_max_unit_test;

    localparam int CYCLE_LIMIT   = 500000;
    localparam int DRAIN_CYCLES  = 40;
    localparam int RANDOM_PHASES = 12;
    localparam int PHASE_WORDS   = 80;

    typedef enum {IDLE_NONE, IDLE_SRC, IDLE_SINK, IDLE_BOTH} idle_mode_t;

    typedef struct {
        logic [wmmm_pkg::OUT_BITS-1:0] raw_now;
        logic [wmmm_pkg::OUT_BITS-1:0] held_min;
        logic [wmmm_pkg::OUT_BITS-1:0] held_mean;
        logic [wmmm_pkg::OUT_BITS-1:0] held_max;
        logic                          window_done;
    } stats_word_t;

    // Tracks the window statistics and holds the words still to come out.
    class stats_scoreboard;
        logic [wmmm_pkg::LEN_BITS-1:0] win_len;
        logic [7:0]                    count;
        logic [23:0]                   acc_sum;
        logic [wmmm_pkg::OUT_BITS-1:0] acc_min;
        logic [wmmm_pkg::OUT_BITS-1:0] acc_max;
        logic [wmmm_pkg::OUT_BITS-1:0] stat_min;
        logic [wmmm_pkg::OUT_BITS-1:0] stat_mean;
        logic [wmmm_pkg::OUT_BITS-1:0] stat_max;
        stats_word_t                   expected_words[$];
        int                            failures;

        function new();
            win_len   = wmmm_pkg::LEN_RESET;
            count     = '0;
            acc_sum   = '0;
            acc_min   = '0;
            acc_max   = '0;
            stat_min  = '0;
            stat_mean = '0;
            stat_max  = '0;
            failures  = 0;
        endfunction

        function void set_window_len(logic [wmmm_pkg::LEN_BITS-1:0] len);
            win_len = len;
        endfunction

        function int pending();
            return expected_words.size();
        endfunction

        function void note_sample(logic [15:0] smp);
            stats_word_t w;
            logic [23:0] quot;
            logic [23:0] divisor;
            w.window_done = 1'b0;
            if (count >= win_len)
            begin
                // zero length divides by one
                divisor   = (win_len == 0) ? 24'd1 : {16'd0, win_len};
                quot      = acc_sum / divisor;
                stat_mean = (quot > {8'd0, wmmm_pkg::OUT_MAX})
                            ? wmmm_pkg::OUT_MAX : quot[wmmm_pkg::OUT_BITS-1:0];
                stat_min  = acc_min;
                stat_max  = acc_max;
                count     = '0;
                acc_sum   = '0;
                acc_min   = '0;
                acc_max   = '0;
                w.window_done = 1'b1;
            end
            else
            begin
                count   = count + 8'd1;
                acc_sum = acc_sum + {8'd0, smp};
                if (count == 8'd1 || smp < acc_min)
                    acc_min = smp;
                if (smp > acc_max)
                    acc_max = smp;
            end
            w.raw_now   = smp;
            w.held_min  = stat_min;
            w.held_mean = stat_mean;
            w.held_max  = stat_max;
            expected_words.push_back(w);
        endfunction

        function void check_word(logic [wmmm_pkg::OUT_FIELDS*wmmm_pkg::OUT_BITS-1:0] data,
                                 logic done);
            stats_word_t exp_w;
            logic [wmmm_pkg::OUT_BITS-1:0] got_raw;
            logic [wmmm_pkg::OUT_BITS-1:0] got_min;
            logic [wmmm_pkg::OUT_BITS-1:0] got_mean;
            logic [wmmm_pkg::OUT_BITS-1:0] got_max;
            if (expected_words.size() == 0)
            begin
                $error("output word with no sample outstanding: tdata %h tuser %b", data, done);
                failures++;
                return;
            end
            exp_w    = expected_words.pop_front();
            got_raw  = data[0*wmmm_pkg::OUT_BITS +: wmmm_pkg::OUT_BITS];
            got_min  = data[1*wmmm_pkg::OUT_BITS +: wmmm_pkg::OUT_BITS];
            got_mean = data[2*wmmm_pkg::OUT_BITS +: wmmm_pkg::OUT_BITS];
            got_max  = data[3*wmmm_pkg::OUT_BITS +: wmmm_pkg::OUT_BITS];
            if (got_raw !== exp_w.raw_now)
            begin
                $error("raw_now: expected %0d, got %0d", exp_w.raw_now, got_raw);
                failures++;
            end
            if (got_min !== exp_w.held_min)
            begin
                $error("held_min: expected %0d, got %0d", exp_w.held_min, got_min);
                failures++;
            end
            if (got_mean !== exp_w.held_mean)
            begin
                $error("held_mean: expected %0d, got %0d", exp_w.held_mean, got_mean);
                failures++;
            end
            if (got_max !== exp_w.held_max)
            begin
                $error("held_max: expected %0d, got %0d", exp_w.held_max, got_max);
                failures++;
            end
            if (done !== exp_w.window_done)
            begin
                $error("window_done: expected %0d, got %0d", exp_w.window_done, done);
                failures++;
            end
        endfunction
    endclass

    logic                               clk;
    logic                               rst_n;
    logic                               s_tvalid;
    logic                               s_tready;
    logic [15:0]                        s_tdata;   // sample
    logic                               m_tvalid;
    logic                               m_tready;
    // raw_now, held_min, held_mean, held_max
    logic [wmmm_pkg::OUT_FIELDS*wmmm_pkg::OUT_BITS-1:0] m_tdata;
    logic                               m_tuser;   // window_done
    logic                               cfg_valid;
    logic                               cfg_ready;
    logic [wmmm_pkg::LEN_BITS-1:0]      cfg_data;  // window_len

    stats_scoreboard sb;
    int unsigned     src_idle_pct;
    int unsigned     sink_stall_pct;
    int unsigned     cycle_count;

    windowed_min_mean_max_unit u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data)
    );

    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    // sink side: random back-pressure, decided at the falling edge
    initial
    begin
        m_tready = 1'b0;
        forever
        begin
            @(negedge clk);
            m_tready <= ($urandom_range(99) >= sink_stall_pct);
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && m_tvalid && m_tready)
            sb.check_word(m_tdata, m_tuser);
    end

    initial
    begin
        cycle_count = 0;
        while (cycle_count < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycle_count++;
        end
        $display("[windowed_min_mean_max_unit] ERROR");
        $finish;
    end

    task automatic set_idling(input idle_mode_t mode);
        case (mode)
            IDLE_NONE: begin src_idle_pct = 0;  sink_stall_pct = 0;  end
            IDLE_SRC:  begin src_idle_pct = 83; sink_stall_pct = 0;  end
            IDLE_SINK: begin src_idle_pct = 0;  sink_stall_pct = 83; end
            default:   begin src_idle_pct = 29; sink_stall_pct = 29; end
        endcase
    endtask

    // returns at the rising edge that accepted the word; valid stays up
    task automatic send_sample(input logic [15:0] smp);
        @(negedge clk);
        while ($urandom_range(99) < src_idle_pct)
        begin
            s_tvalid <= 1'b0;
            @(negedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= smp;
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        sb.note_sample(smp);
    endtask

    task automatic drain_outputs();
        @(negedge clk);
        s_tvalid <= 1'b0;
        while (sb.pending() != 0)
            @(posedge clk);
    endtask

    task automatic write_window_len(input logic [wmmm_pkg::LEN_BITS-1:0] len);
        drain_outputs();
        @(negedge clk);
        cfg_valid <= 1'b1;
        cfg_data  <= len;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        sb.set_window_len(len);
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    function automatic logic [15:0] pick_sample();
        case ($urandom_range(9))
            0:       return 16'h0000;
            1:       return 16'hFFFF;
            2:       return 16'($urandom_range(15));
            3:       return 16'($urandom_range(65535, 65520));
            default: return 16'($urandom);
        endcase
    endfunction

    function automatic logic [wmmm_pkg::LEN_BITS-1:0] pick_window_len(input int phase);
        case (phase % 8)
            0: return 8'd4;
            1: return 8'd255;
            2: return 8'd1;
            3: return 8'd0;
            4: return wmmm_pkg::LEN_RESET;
            5: return 8'($urandom_range(20, 2));
            6: return 8'd2;
            default: return 8'($urandom_range(255, 1));
        endcase
    endfunction

    initial
    begin
        logic [15:0] opening_run[7];
        logic [15:0] smp;
        sb = new();
        rst_n     = 1'b0;
        s_tvalid  = 1'b0;
        s_tdata   = '0;
        cfg_valid = 1'b0;
        cfg_data  = '0;
        set_idling(IDLE_NONE);
        repeat (12) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // extremes at the reset length, then lower to 2: sum/2 saturates
        opening_run = '{16'h0000, 16'hFFFF, 16'h0001, 16'hAAAA,
                        16'h5555, 16'h8000, 16'h7FFF};
        foreach (opening_run[i])
            send_sample(opening_run[i]);
        write_window_len(8'd2);
        send_sample(16'd11);
        send_sample(16'd5);
        send_sample(16'd3);
        send_sample(16'd99);

        // zero length straight after a partial window: mean is the sum, clipped
        write_window_len(8'd4);
        send_sample(16'hFFFF);
        send_sample(16'hFFFF);
        write_window_len(8'd0);
        send_sample(16'd7);
        send_sample(16'd9);

        // length raised mid-window keeps accumulating
        write_window_len(8'd3);
        send_sample(16'd10);
        send_sample(16'd20);
        write_window_len(8'd6);
        send_sample(16'd30);
        send_sample(16'd40);
        send_sample(16'd50);
        send_sample(16'd60);
        send_sample(16'd1234);

        for (int p = 0; p < RANDOM_PHASES; p++)
        begin
            write_window_len(pick_window_len(p));
            set_idling(idle_mode_t'(p % 4));
            for (int n = 0; n < PHASE_WORDS; n++)
            begin
                smp = pick_sample();
                send_sample(smp);
            end
        end

        drain_outputs();
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (sb.failures == 0 && sb.pending() == 0)
            $display("[windowed_min_mean_max_unit] OK");
        else
            $display("[windowed_min_mean_max_unit] ERROR");
        $finish;
    end

endmodule
